// ===== design/mrfd_pkg.sv =====
// ---------------------------------------------------------------------------
// mrfd_pkg: shared types and constants for the meter reply frame decoder
// Frame byte positions, identifier constant, result status codes and the
// decimal weights of the four reading bytes.
// ---------------------------------------------------------------------------
`default_nettype none

package mrfd_pkg;

   localparam int unsigned ENERGY_W = 28;
   localparam int unsigned COUNT_W  = 5;

   localparam logic [7:0] ID_BYTE = 8'h33;

   localparam logic [COUNT_W-1:0] IDLE_COUNT  = 5'd19;
   localparam logic [COUNT_W-1:0] CHECK_INDEX = 5'd18;
   localparam logic [COUNT_W-1:0] ID_FIRST    = 5'd10;
   localparam logic [COUNT_W-1:0] ID_SECOND   = 5'd11;
   localparam logic [COUNT_W-1:0] DATA_FIRST  = 5'd14;
   localparam logic [COUNT_W-1:0] DATA_LAST   = 5'd17;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = 28'd166666665;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ID_FAIL  = 2'd1,
      STATUS_SUM_FAIL = 2'd2
   } status_type;

   typedef logic [1:0] data_pos_type;

   // weight of the high nibble of each reading byte, lowest byte first
   function automatic logic [ENERGY_W-1:0] high_weight(input data_pos_type pos);
      logic [ENERGY_W-1:0] w;
      case (pos)
         2'd0: w = 28'd10;
         2'd1: w = 28'd1000;
         2'd2: w = 28'd100000;
         2'd3: w = 28'd10000000;
         default: w = 28'd0;
      endcase
      return w;
   endfunction

   // weight of the low nibble, one tenth of the high one
   function automatic logic [ENERGY_W-1:0] low_weight(input data_pos_type pos);
      logic [ENERGY_W-1:0] w;
      case (pos)
         2'd0: w = 28'd1;
         2'd1: w = 28'd100;
         2'd2: w = 28'd10000;
         2'd3: w = 28'd1000000;
         default: w = 28'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== design/mrfd_byte_decode.sv =====
// ---------------------------------------------------------------------------
// mrfd_byte_decode: weighted value of one reading byte
// Removes the 0x33 offset and weights both nibbles as decimal digits at the
// byte's place in the reading. Nibbles above nine keep their weight.
// ---------------------------------------------------------------------------
`default_nettype none

module mrfd_byte_decode
   import mrfd_pkg::*;
(
   input  wire logic [7:0]          raw_byte,
   input  wire data_pos_type        pos,
   output logic [ENERGY_W-1:0]      value
);

   logic [7:0] plain;
   logic [ENERGY_W-1:0] hi_term;
   logic [ENERGY_W-1:0] lo_term;

   always_comb begin
      plain   = raw_byte - ID_BYTE;
      hi_term = ENERGY_W'(plain[7:4]) * high_weight(pos);
      lo_term = ENERGY_W'(plain[3:0]) * low_weight(pos);
      value   = hi_term + lo_term;
   end

endmodule

`default_nettype wire

// ===== design/meter_reply_frame_decoder.sv =====
// result path: a request is registered at acceptance and its result, if any,
//   is loaded into the result register, which drives rsp_tvalid; a checksum
//   byte waits in the input register until the result register is free
// throughput: one byte per cycle unless stalled; byte state updates once per byte,
//   and the decimal reading is built up one data byte at a time as bytes arrive
// reset: synchronous, active high; clears the pipeline, byte count goes idle,
//   the held reading goes to zero
// ---------------------------------------------------------------------------
// meter_reply_frame_decoder: energy meter reply frame decoder
// Sums frame bytes, checks identifier and checksum, and gives the decoded
// reading (or the last good one) at each checksum byte.
// ---------------------------------------------------------------------------
`default_nettype none

module meter_reply_frame_decoder
   import mrfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0]  req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [1:0] status, [29:2] energy, [31:30] zero
);

   // input register
   logic       stg_vld_ff;
   logic [7:0] stg_byte_ff;
   logic       stg_start_ff;

   // frame state
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [7:0]          sum_ff, sum_in;
   logic                id_ok_ff, id_ok_in;
   logic [ENERGY_W-1:0] acc_ff, acc_in;
   logic [ENERGY_W-1:0] held_ff, held_in;

   // result register
   logic                out_vld_ff, out_vld_in;
   status_type          out_status_ff, out_status_in;
   logic [ENERGY_W-1:0] out_energy_ff, out_energy_in;

   logic                req_accept;
   logic                out_free;
   logic                advance;
   logic                active;
   logic                is_check;
   logic [COUNT_W-1:0]  cur_idx;
   logic [7:0]          sum_base;
   logic                id_base;
   logic [ENERGY_W-1:0] acc_base;
   data_pos_type        data_off;
   logic [ENERGY_W-1:0] byte_value;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign cur_idx    = stg_start_ff ? '0 : count_ff;
   assign active     = stg_start_ff || (count_ff < IDLE_COUNT);
   assign is_check   = active && (cur_idx == CHECK_INDEX);
   // an item that yields a result waits for a free result register
   assign advance    = stg_vld_ff && (!is_check || out_free);
   assign req_tready = !stg_vld_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign data_off = data_pos_type'(cur_idx - DATA_FIRST);

   mrfd_byte_decode u_decode (
      .raw_byte (stg_byte_ff),
      .pos      (data_off),
      .value    (byte_value)
   );

   always_comb begin
      sum_base = stg_start_ff ? '0 : sum_ff;
      id_base  = stg_start_ff ? 1'b1 : id_ok_ff;
      acc_base = stg_start_ff ? '0 : acc_ff;

      count_in      = count_ff;
      sum_in        = sum_ff;
      id_ok_in      = id_ok_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      out_vld_in    = out_vld_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_energy_in = out_energy_ff;

      if (advance && active) begin
         if (is_check) begin
            count_in   = IDLE_COUNT;
            out_vld_in = 1'b1;
            if (!id_ok_ff) begin
               out_status_in = STATUS_ID_FAIL;
               out_energy_in = held_ff;
            end else if (sum_ff != stg_byte_ff) begin
               out_status_in = STATUS_SUM_FAIL;
               out_energy_in = held_ff;
            end else begin
               out_status_in = STATUS_OK;
               out_energy_in = acc_ff;
               held_in       = acc_ff;
            end
         end else begin
            count_in = cur_idx + 1'b1;
            sum_in   = sum_base + stg_byte_ff;
            id_ok_in = id_base;
            if ((cur_idx == ID_FIRST || cur_idx == ID_SECOND) && stg_byte_ff != ID_BYTE) begin
               id_ok_in = 1'b0;
            end
            acc_in = acc_base;
            if (cur_idx >= DATA_FIRST && cur_idx <= DATA_LAST) begin
               acc_in = acc_base + byte_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         count_ff   <= IDLE_COUNT;
         sum_ff     <= '0;
         id_ok_ff   <= 1'b1;
         acc_ff     <= '0;
         held_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            stg_vld_ff <= 1'b1;
         end else if (advance) begin
            stg_vld_ff <= 1'b0;
         end
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         id_ok_ff   <= id_ok_in;
         acc_ff     <= acc_in;
         held_ff    <= held_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_byte_ff  <= req_tdata;
         stg_start_ff <= req_tuser[0];
      end
      out_status_ff <= out_status_in;
      out_energy_ff <= out_energy_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_energy_ff, out_status_ff};

endmodule

`default_nettype wire

// ===== design/mrfd_checker.sv =====
// ---------------------------------------------------------------------------
// mrfd_checker: port-level checks for the meter reply frame decoder
// Watches the request and result channels and checks reading bounds,
// reading hold on rejected frames and result timing.
// ---------------------------------------------------------------------------
`default_nettype none

module mrfd_checker
   import mrfd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   logic [ENERGY_W-1:0] last_energy_ff;
   logic [ENERGY_W-1:0] rsp_energy;
   logic [1:0]          rsp_status;
   logic                rsp_accept;
   logic                req_accept;

   assign rsp_energy = rsp_tdata[29:2];
   assign rsp_status = rsp_tdata[1:0];
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // last reading delivered on the result channel
   always_ff @(posedge clock) begin
      if (reset) begin
         last_energy_ff <= '0;
      end else if (rsp_accept) begin
         last_energy_ff <= rsp_energy;
      end
   end

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a rejected frame repeats the last delivered reading
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != STATUS_OK |-> rsp_energy == last_energy_ff)
      else $error("rejected frame changed the reading");

   // reading never exceeds eight digits of weight fifteen
   a_energy_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_energy <= ENERGY_MAX && rsp_tdata[31:30] == 2'b00)
      else $error("reading out of range");

   // a new result must follow an accepted request
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_accept, 2))
      else $error("result without a preceding request");

endmodule

bind meter_reply_frame_decoder mrfd_checker u_mrfd_checker (.*);

`default_nettype wire
